>>> hw/rtl/dhlt_pkg.sv
// Shared types and constants for the DH link transform pipeline.
// Used by the prep stage, the CORDIC cells, the output stage and the top level.
// No dependencies.
package dhlt_pkg;

    localparam int XY_W         = 34;
    localparam int Z_W          = 32;
    localparam int ANG_W        = 18;
    localparam int TURN_W       = 16;
    localparam int FOLD_W       = 15;
    localparam int LEN_W        = 24;
    localparam int Q15_W        = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int THREE_QUARTER = 34560;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic signed [Z_W-1:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
        32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
        32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
        32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
        32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
        32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
        32'sd458,       32'sd229,       32'sd115,       32'sd57
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } rot_t;

    typedef struct packed {
        logic                    th_neg;
        logic                    al_neg;
        logic signed [LEN_W-1:0] ext;
    } side_t;

    typedef struct packed {
        rot_t  th;
        rot_t  al;
        side_t side;
    } cell_data_t;

    typedef struct packed {
        logic signed [Q15_W-1:0] m00;
        logic signed [Q15_W-1:0] m01;
        logic signed [Q15_W-1:0] m02;
        logic signed [LEN_W-1:0] m03;
        logic signed [Q15_W-1:0] m10;
        logic signed [Q15_W-1:0] m11;
        logic signed [Q15_W-1:0] m12;
        logic signed [LEN_W-1:0] m13;
        logic signed [Q15_W-1:0] m21;
        logic signed [Q15_W-1:0] m22;
        logic signed [LEN_W-1:0] m23;
    } mat_t;

endpackage

>>> hw/rtl/dhlt_prep.sv
// Input stages: angle sums wrapped to one turn, folded to +/-90 degrees, extension sum.
// Two pipeline stages; the second loads the CORDIC start vectors.
// Depends on dhlt_pkg.
module dhlt_prep
    import dhlt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic signed [16:0]       joint_angle,
    input  logic signed [LEN_W-1:0]  joint_extension,
    input  logic signed [15:0]       twist_angle,
    input  logic signed [16:0]       angle_offset,
    input  logic signed [LEN_W-1:0]  extension_offset,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output cell_data_t               dn_data
);

    localparam int WRAP_BIAS  = 3 * FULL_TURN;
    localparam int WRAP_TURNS = 5;
    localparam int EXT_MAX    = (1 << (LEN_W - 1)) - 1;
    localparam int EXT_MIN    = -(1 << (LEN_W - 1));

    function automatic logic [TURN_W-1:0] wrap_turn(input logic signed [ANG_W-1:0] a);
        logic [ANG_W:0] s;
        logic [ANG_W:0] sub;
        s = $unsigned((ANG_W + 1)'(a) + (ANG_W + 1)'(WRAP_BIAS));
        sub = '0;
        for (int k = 1; k <= WRAP_TURNS; k++)
        begin
            if (s >= (ANG_W + 1)'(k * FULL_TURN))
            begin
                sub = (ANG_W + 1)'(k * FULL_TURN);
            end
        end
        return TURN_W'(s - sub);
    endfunction

    function automatic logic [FOLD_W:0] fold_turn(input logic [TURN_W-1:0] t);
        logic signed [TURN_W:0] ts;
        logic signed [TURN_W:0] fs;
        logic                   neg;
        ts = $signed({1'b0, t});
        fs = ts;
        neg = 1'b0;
        if (t >= TURN_W'(THREE_QUARTER))
        begin
            fs = ts - (TURN_W + 1)'(FULL_TURN);
        end
        else if (t > TURN_W'(QUARTER_TURN))
        begin
            fs = ts - (TURN_W + 1)'(HALF_TURN);
            neg = 1'b1;
        end
        return {neg, fs[FOLD_W-1:0]};
    endfunction

    function automatic rot_t start_vector(input logic signed [FOLD_W-1:0] f);
        rot_t                  r;
        logic signed [Z_W-1:0] fz;
        fz = Z_W'(f);
        r.x = XY_W'(CORDIC_GAIN);
        r.y = '0;
        r.z = {fz[Z_W-17:0], 16'b0};
        return r;
    endfunction

    logic                    v0_reg;
    logic                    v1_reg;
    logic [TURN_W-1:0]       th_wrap_reg;
    logic [TURN_W-1:0]       al_wrap_reg;
    logic signed [LEN_W-1:0] ext_reg;
    cell_data_t              data_reg;

    logic                    ld0;
    logic                    ld1;
    logic signed [ANG_W-1:0] th_sum;
    logic signed [LEN_W:0]   ext_sum;
    logic signed [LEN_W-1:0] ext_next;
    logic [FOLD_W:0]         th_fold;
    logic [FOLD_W:0]         al_fold;
    cell_data_t              data_next;

    assign ld1      = !v1_reg || dn_ready;
    assign ld0      = !v0_reg || ld1;
    assign up_ready = ld0;
    assign dn_valid = v1_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        th_sum  = ANG_W'(joint_angle) + ANG_W'(angle_offset);
        ext_sum = (LEN_W + 1)'(joint_extension) + (LEN_W + 1)'(extension_offset);
        if (ext_sum > (LEN_W + 1)'(EXT_MAX))
        begin
            ext_next = LEN_W'(EXT_MAX);
        end
        else if (ext_sum < (LEN_W + 1)'(EXT_MIN))
        begin
            ext_next = LEN_W'(EXT_MIN);
        end
        else
        begin
            ext_next = ext_sum[LEN_W-1:0];
        end
    end

    always_comb
    begin
        th_fold = fold_turn(th_wrap_reg);
        al_fold = fold_turn(al_wrap_reg);
        data_next.th = start_vector(th_fold[FOLD_W-1:0]);
        data_next.al = start_vector(al_fold[FOLD_W-1:0]);
        data_next.side.th_neg = th_fold[FOLD_W];
        data_next.side.al_neg = al_fold[FOLD_W];
        data_next.side.ext = ext_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (ld0)
            begin
                v0_reg <= up_valid;
            end
            if (ld1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            th_wrap_reg <= wrap_turn(th_sum);
            al_wrap_reg <= wrap_turn(ANG_W'(twist_angle));
            ext_reg     <= ext_next;
        end
        if (ld1)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/dhlt_cordic_cell.sv
// One CORDIC rotation step for the joint angle and the twist angle.
// Each cell holds one request and hands it to the next cell when that cell can take it.
// Depends on dhlt_pkg.
module dhlt_cordic_cell
    import dhlt_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  cell_data_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output cell_data_t dn_data
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = ATAN_TABLE[STEP];

    function automatic rot_t rotate(input rot_t r);
        rot_t q;
        if (r.z >= 0)
        begin
            q.x = r.x - (r.y >>> STEP);
            q.y = r.y + (r.x >>> STEP);
            q.z = r.z - ATAN_STEP;
        end
        else
        begin
            q.x = r.x + (r.y >>> STEP);
            q.y = r.y - (r.x >>> STEP);
            q.z = r.z + ATAN_STEP;
        end
        return q;
    endfunction

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;
    logic       ld;

    assign ld       = !valid_reg || dn_ready;
    assign up_ready = ld;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.th   = rotate(up_data.th);
        data_next.al   = rotate(up_data.al);
        data_next.side = up_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/dhlt_post.sv
// Output stages: sine and cosine rounding, the six products, product rounding.
// Three pipeline stages; the last is the output register of the block.
// Depends on dhlt_pkg.
module dhlt_post
    import dhlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  cell_data_t              up_data,
    input  logic signed [LEN_W-1:0] link_length,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output mat_t                    dn_data
);

    localparam int PROD_W  = 41;
    localparam int Q15_MAX = (1 << (Q15_W - 1)) - 1;
    localparam int LEN_MAX = (1 << (LEN_W - 1)) - 1;
    localparam int HALF_LSB = 1 << 14;

    function automatic logic signed [LEN_W-1:0] rnd_sat(
        input logic signed [PROD_W-1:0] v,
        input logic signed [PROD_W-1:0] hi
    );
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] r;
        s = (v + PROD_W'(HALF_LSB)) >>> 15;
        if (s > hi)
        begin
            r = hi;
        end
        else if (s < -hi - 1)
        begin
            r = -hi - 1;
        end
        else
        begin
            r = s;
        end
        return r[LEN_W-1:0];
    endfunction

    function automatic logic signed [Q15_W-1:0] to_q15(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [PROD_W-1:0] e;
        logic signed [LEN_W-1:0]  r;
        e = PROD_W'(v);
        if (neg)
        begin
            e = -e;
        end
        r = rnd_sat(e, PROD_W'(Q15_MAX));
        return r[Q15_W-1:0];
    endfunction

    logic                    va_reg;
    logic                    vb_reg;
    logic                    vc_reg;
    logic signed [Q15_W-1:0] st_reg;
    logic signed [Q15_W-1:0] ct_reg;
    logic signed [Q15_W-1:0] sa_reg;
    logic signed [Q15_W-1:0] ca_reg;
    logic signed [LEN_W-1:0] ext_reg;
    logic signed [Q15_W-1:0] st_b_reg;
    logic signed [Q15_W-1:0] ct_b_reg;
    logic signed [Q15_W-1:0] sa_b_reg;
    logic signed [Q15_W-1:0] ca_b_reg;
    logic signed [LEN_W-1:0] ext_b_reg;
    logic signed [31:0]      st_ca_reg;
    logic signed [31:0]      st_sa_reg;
    logic signed [31:0]      ct_ca_reg;
    logic signed [31:0]      ct_sa_reg;
    logic signed [39:0]      len_ct_reg;
    logic signed [39:0]      len_st_reg;
    mat_t                    mat_reg;
    mat_t                    mat_next;

    logic lda;
    logic ldb;
    logic ldc;

    assign ldc      = !vc_reg || dn_ready;
    assign ldb      = !vb_reg || ldc;
    assign lda      = !va_reg || ldb;
    assign up_ready = lda;
    assign dn_valid = vc_reg;
    assign dn_data  = mat_reg;

    always_comb
    begin
        mat_next.m00 = ct_b_reg;
        mat_next.m01 = Q15_W'(rnd_sat(-PROD_W'(st_ca_reg), PROD_W'(Q15_MAX)));
        mat_next.m02 = Q15_W'(rnd_sat(PROD_W'(st_sa_reg), PROD_W'(Q15_MAX)));
        mat_next.m03 = rnd_sat(PROD_W'(len_ct_reg), PROD_W'(LEN_MAX));
        mat_next.m10 = st_b_reg;
        mat_next.m11 = Q15_W'(rnd_sat(PROD_W'(ct_ca_reg), PROD_W'(Q15_MAX)));
        mat_next.m12 = Q15_W'(rnd_sat(-PROD_W'(ct_sa_reg), PROD_W'(Q15_MAX)));
        mat_next.m13 = rnd_sat(PROD_W'(len_st_reg), PROD_W'(LEN_MAX));
        mat_next.m21 = sa_b_reg;
        mat_next.m22 = ca_b_reg;
        mat_next.m23 = ext_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (lda)
            begin
                va_reg <= up_valid;
            end
            if (ldb)
            begin
                vb_reg <= va_reg;
            end
            if (ldc)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lda)
        begin
            st_reg  <= to_q15(up_data.th.y, up_data.side.th_neg);
            ct_reg  <= to_q15(up_data.th.x, up_data.side.th_neg);
            sa_reg  <= to_q15(up_data.al.y, up_data.side.al_neg);
            ca_reg  <= to_q15(up_data.al.x, up_data.side.al_neg);
            ext_reg <= up_data.side.ext;
        end
        if (ldb)
        begin
            st_b_reg   <= st_reg;
            ct_b_reg   <= ct_reg;
            sa_b_reg   <= sa_reg;
            ca_b_reg   <= ca_reg;
            ext_b_reg  <= ext_reg;
            st_ca_reg  <= 32'(st_reg) * 32'(ca_reg);
            st_sa_reg  <= 32'(st_reg) * 32'(sa_reg);
            ct_ca_reg  <= 32'(ct_reg) * 32'(ca_reg);
            ct_sa_reg  <= 32'(ct_reg) * 32'(sa_reg);
            len_ct_reg <= 40'(link_length) * 40'(ct_reg);
            len_st_reg <= 40'(link_length) * 40'(st_reg);
        end
        if (ldc)
        begin
            mat_reg <= mat_next;
        end
    end

endmodule

>>> hw/rtl/dh_link_transform_top.sv
// Top level of the DH link transform: configuration registers, input stages,
// a row of CORDIC cells and the output stages. Depends on dhlt_pkg and all dhlt_ modules.
// From acceptance to out_valid a request passes two input stages, one CORDIC cell per
// iteration (iterations above 24 count as 24) and three output stages, the first input
// stage loading at the accepting edge. Throughput is one request per cycle while the
// output is not stalled; every stage advances into a free or moving slot.
// Reset clears all stage valid flags and the configuration registers to zero.
module dh_link_transform_top
    import dhlt_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [16:0]      joint_angle,
    input  logic signed [LEN_W-1:0] joint_extension,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [Q15_W-1:0] m00,
    output logic signed [Q15_W-1:0] m01,
    output logic signed [Q15_W-1:0] m02,
    output logic signed [LEN_W-1:0] m03,
    output logic signed [Q15_W-1:0] m10,
    output logic signed [Q15_W-1:0] m11,
    output logic signed [Q15_W-1:0] m12,
    output logic signed [LEN_W-1:0] m13,
    output logic signed [Q15_W-1:0] m21,
    output logic signed [Q15_W-1:0] m22,
    output logic signed [LEN_W-1:0] m23
);

    localparam int NUM_CELLS = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                               TRIG_ITERATIONS;

    localparam logic [1:0] REG_TWIST  = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_AOFF   = 2'd2;
    localparam logic [1:0] REG_DOFF   = 2'd3;

    logic signed [15:0]      twist_reg;
    logic signed [LEN_W-1:0] length_reg;
    logic signed [16:0]      aoff_reg;
    logic signed [LEN_W-1:0] doff_reg;
    logic                    wr_en;

    logic       chain_valid [0:NUM_CELLS];
    logic       chain_ready [0:NUM_CELLS];
    cell_data_t chain_data  [0:NUM_CELLS];
    logic       prep_ready;
    mat_t       mat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twist_reg  <= '0;
            length_reg <= '0;
            aoff_reg   <= '0;
            doff_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_TWIST:  twist_reg  <= pwdata[15:0];
                REG_LENGTH: length_reg <= pwdata[LEN_W-1:0];
                REG_AOFF:   aoff_reg   <= pwdata[16:0];
                REG_DOFF:   doff_reg   <= pwdata[LEN_W-1:0];
                default:    twist_reg  <= twist_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TWIST:  prdata = {16'b0, twist_reg};
            REG_LENGTH: prdata = {8'b0, length_reg};
            REG_AOFF:   prdata = {15'b0, aoff_reg};
            REG_DOFF:   prdata = {8'b0, doff_reg};
            default:    prdata = '0;
        endcase
    end

    assign in_stall = !prep_ready;

    dhlt_prep u_prep (
        .clk              (clk),
        .rst_n            (rst_n),
        .up_valid         (in_valid),
        .up_ready         (prep_ready),
        .joint_angle      (joint_angle),
        .joint_extension  (joint_extension),
        .twist_angle      (twist_reg),
        .angle_offset     (aoff_reg),
        .extension_offset (doff_reg),
        .dn_valid         (chain_valid[0]),
        .dn_ready         (chain_ready[0]),
        .dn_data          (chain_data[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        dhlt_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_data  (chain_data[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_data  (chain_data[g+1])
        );
    end

    dhlt_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (chain_valid[NUM_CELLS]),
        .up_ready    (chain_ready[NUM_CELLS]),
        .up_data     (chain_data[NUM_CELLS]),
        .link_length (length_reg),
        .dn_valid    (out_valid),
        .dn_ready    (!out_stall),
        .dn_data     (mat)
    );

    assign m00 = mat.m00;
    assign m01 = mat.m01;
    assign m02 = mat.m02;
    assign m03 = mat.m03;
    assign m10 = mat.m10;
    assign m11 = mat.m11;
    assign m12 = mat.m12;
    assign m13 = mat.m13;
    assign m21 = mat.m21;
    assign m22 = mat.m22;
    assign m23 = mat.m23;

    // The input can only be held off when the whole pipeline is backed up behind the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output register is free");

    a_twist_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && paddr[3:2] == REG_TWIST) |=> twist_reg == $past(pwdata[15:0]))
        else $error("twist register write lost");

    a_length_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && paddr[3:2] == REG_LENGTH) |=> length_reg == $past(pwdata[LEN_W-1:0]))
        else $error("link length register write lost");

endmodule

>>> test/testbench.sv
// Self-checking testbench for dh_link_transform_top: random and directed joint samples,
// register writes over the APB-style port, and a matrix predictor built on the CORDIC steps.
// Depends on dhlt_pkg and the RTL of the DH link transform.
module testbench;
    import dhlt_pkg::*;

    localparam int TRIG_STEPS = 16;
    localparam int STEPS_USED = (TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS;
    localparam int PIPE_DELAY = TRIG_STEPS + 5;
    localparam int HOLD_CYCLES = 200;
    localparam int STUCK_LIMIT = 2000;
    localparam int MAX_REPORTS = 100;

    typedef enum int unsigned {
        REG_TWIST,
        REG_LENGTH,
        REG_ANGLE_OFFSET,
        REG_EXT_OFFSET
    } link_reg_e;

    typedef struct {
        logic signed [16:0]      angle;
        logic signed [LEN_W-1:0] ext;
    } joint_sample_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [3:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [16:0]      joint_angle = '0;
    logic signed [LEN_W-1:0] joint_extension = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [Q15_W-1:0] m00, m01, m02, m10, m11, m12, m21, m22;
    logic signed [LEN_W-1:0] m03, m13, m23;

    logic signed [15:0]      twist_cfg = '0;
    logic signed [LEN_W-1:0] length_cfg = '0;
    logic signed [16:0]      angle_offset_cfg = '0;
    logic signed [LEN_W-1:0] ext_offset_cfg = '0;

    joint_sample_t pending_samples[$];
    mat_t          expected_matrices[$];

    int send_idle_pct = 20;
    int recv_stall_pct = 20;
    int hold_requests = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int stuck_cycles = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int matrices_checked = 0;
    int register_writes = 0;

    dh_link_transform_top #(
        .TRIG_ITERATIONS(TRIG_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .joint_angle(joint_angle),
        .joint_extension(joint_extension),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .m00(m00),
        .m01(m01),
        .m02(m02),
        .m03(m03),
        .m10(m10),
        .m11(m11),
        .m12(m12),
        .m13(m13),
        .m21(m21),
        .m22(m22),
        .m23(m23)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint round_sat(input longint v, input int w);
        return saturate((v + 16384) >>> 15, w);
    endfunction

    function automatic void trig_q15(input longint angle, output longint s, output longint c);
        longint t;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        t = angle % FULL_TURN;
        if (t < 0)
            t += FULL_TURN;
        flip = 1'b0;
        if (t >= THREE_QUARTER)
            t -= FULL_TURN;
        else if (t > QUARTER_TURN)
        begin
            t -= HALF_TURN;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = t * 65536;
        for (int k = 0; k < STEPS_USED; k++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> k);
                y = y + (x >>> k);
                z -= longint'(ATAN_TABLE[k]);
            end
            else
            begin
                nx = x + (y >>> k);
                y = y - (x >>> k);
                z += longint'(ATAN_TABLE[k]);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = round_sat(x, 16);
        s = round_sat(y, 16);
    endfunction

    function automatic mat_t link_matrix(input logic signed [16:0] angle,
                                         input logic signed [LEN_W-1:0] ext);
        longint st;
        longint ct;
        longint sa;
        longint ca;
        longint a;
        mat_t   m;
        trig_q15(longint'(angle) + longint'(angle_offset_cfg), st, ct);
        trig_q15(longint'(twist_cfg), sa, ca);
        a = longint'(length_cfg);
        m.m00 = Q15_W'(ct);
        m.m01 = Q15_W'(round_sat(-(st * ca), 16));
        m.m02 = Q15_W'(round_sat(st * sa, 16));
        m.m03 = LEN_W'(round_sat(a * ct, 24));
        m.m10 = Q15_W'(st);
        m.m11 = Q15_W'(round_sat(ct * ca, 16));
        m.m12 = Q15_W'(round_sat(-(ct * sa), 16));
        m.m13 = LEN_W'(round_sat(a * st, 24));
        m.m21 = Q15_W'(sa);
        m.m22 = Q15_W'(ca);
        m.m23 = LEN_W'(saturate(longint'(ext) + longint'(ext_offset_cfg), 24));
        return m;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Driver: a new request is offered only when the slot is empty or just accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_matrices.push_back(link_matrix(joint_angle, joint_extension));
                samples_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    joint_angle <= pending_samples[0].angle;
                    joint_extension <= pending_samples[0].ext;
                    void'(pending_samples.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_requests)
        begin
            hold_taken <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        mat_t got;
        mat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {m00, m01, m02, m03, m10, m11, m12, m13, m21, m22, m23};
            if (expected_matrices.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result arrived with no request outstanding", $time);
            end
            else
            begin
                want = expected_matrices.pop_front();
                matrices_checked++;
                check_field("m00", longint'(want.m00), longint'(got.m00));
                check_field("m01", longint'(want.m01), longint'(got.m01));
                check_field("m02", longint'(want.m02), longint'(got.m02));
                check_field("m03", longint'(want.m03), longint'(got.m03));
                check_field("m10", longint'(want.m10), longint'(got.m10));
                check_field("m11", longint'(want.m11), longint'(got.m11));
                check_field("m12", longint'(want.m12), longint'(got.m12));
                check_field("m13", longint'(want.m13), longint'(got.m13));
                check_field("m21", longint'(want.m21), longint'(got.m21));
                check_field("m22", longint'(want.m22), longint'(got.m22));
                check_field("m23", longint'(want.m23), longint'(got.m23));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(input link_reg_e idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(int'(idx) * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TWIST:        twist_cfg = value[15:0];
            REG_LENGTH:       length_cfg = value[23:0];
            REG_ANGLE_OFFSET: angle_offset_cfg = value[16:0];
            REG_EXT_OFFSET:   ext_offset_cfg = value[23:0];
            default:          ;
        endcase
        register_writes++;
    endtask

    task automatic write_links(input int twist, input int length, input int angle_off,
                               input int ext_off);
        write_reg(REG_TWIST, twist);
        write_reg(REG_LENGTH, length);
        write_reg(REG_ANGLE_OFFSET, angle_off);
        write_reg(REG_EXT_OFFSET, ext_off);
    endtask

    task automatic queue_sample(input int angle, input int ext);
        joint_sample_t s;
        s.angle = 17'(angle);
        s.ext = LEN_W'(ext);
        pending_samples.push_back(s);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_matrices.size() != 0);
        repeat (PIPE_DELAY + 4) @(negedge clk);
    endtask

    function automatic int pick_angle();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return int'($urandom_range(92160)) - 46080;
        else if (sel < 8)
            return int'($urandom_range(16)) * 5760 - 46080 + int'($urandom_range(2)) - 1;
        else
            return int'($urandom());
    endfunction

    function automatic int pick_extension();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 8388607 - int'($urandom_range(3));
        else if (sel == 1)
            return -8388608 + int'($urandom_range(3));
        else
            return int'($urandom());
    endfunction

    function automatic int pick_twist();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return int'($urandom_range(46080)) - 23040;
        else if (sel < 8)
            return int'($urandom_range(8)) * 5760 - 23040;
        else
            return int'($urandom());
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_sample(0, 0);
        queue_sample(11520, 8388607);
        queue_sample(-11520, -8388608);
        queue_sample(23040, 1);
        queue_sample(34560, -1);
        queue_sample(46080, 0);
        queue_sample(-46080, 0);
        queue_sample(65535, 12345);
        queue_sample(-65536, -12345);
        queue_sample(11519, 0);
        wait_drained();

        write_links(-32768, 8388607, 65535, 8388607);
        queue_sample(0, 8388607);
        queue_sample(65535, 1);
        queue_sample(-65536, -8388608);
        queue_sample(11520, 0);
        queue_sample(-11520, 0);
        queue_sample(23040, 100);
        queue_sample(40000, -100);
        wait_drained();

        write_links(11520, -8388608, -65536, -8388608);
        queue_sample(0, -8388608);
        queue_sample(65535, -1);
        queue_sample(-65536, 8388607);
        queue_sample(0, 0);
        queue_sample(23040, 0);
        queue_sample(34560, 0);
        queue_sample(-23040, 5);
        wait_drained();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 7 : ((mode == 1) ? 68 : 0);
            recv_stall_pct = (mode == 0) ? 68 : ((mode == 1) ? 7 : 0);
            for (int part = 0; part < 2; part++)
            begin
                write_links(pick_twist(), int'($urandom()), pick_angle(), pick_extension());
                if (mode == 2 && part == 0)
                    hold_requests++;
                repeat (271) queue_sample(pick_angle(), pick_extension());
                wait_drained();
            end
        end

        mismatch_count += expected_matrices.size();
        $display("Sent %0d joint samples across %0d register writes and checked %0d matrices,",
                 samples_sent, register_writes, matrices_checked);
        $display("with both sides idling in turn and one %0d-cycle output hold.", HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dhlt_pkg.sv
hw/rtl/dhlt_prep.sv
hw/rtl/dhlt_cordic_cell.sv
hw/rtl/dhlt_post.sv
hw/rtl/dh_link_transform_top.sv
test/testbench.sv
